// ===== hdl/rtmp_chunk_serializer_unit_assert.svh =====
// Assertion macros for the chunk serializer.
// Uses clk_i and rst_ni of the including module; define ASSERT_OFF to drop all checks.
`ifndef RTMP_CHUNK_SERIALIZER_UNIT_ASSERT_SVH
`define RTMP_CHUNK_SERIALIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RCS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RCS_ASSERT(lbl, prop, msg)
`define RCS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/rcs_pkg.sv =====
// Shared types, constants and the basic header encoder of the chunk serializer.
// No dependencies; imported by every module of the block.
package rcs_pkg;

  localparam int RCS_PADDR_W = 3;
  localparam int RCS_QDEPTH  = 4;
  localparam int RCS_QPTR_W  = $clog2(RCS_QDEPTH);

  localparam logic [16:0] RCS_MAX_CHUNK_RST   = 17'd128;
  localparam logic [16:0] RCS_MAX_CHUNK_LIMIT = 17'd65536;
  localparam logic [16:0] RCS_CSID_MIN       = 17'd2;
  localparam logic [16:0] RCS_CSID_MAX       = 17'd65599;
  localparam logic [16:0] RCS_CSID_ONE_MAX   = 17'd63;
  localparam logic [16:0] RCS_CSID_BASE      = 17'd64;
  localparam logic [16:0] RCS_CSID_TWO_MAX   = 17'd319;

  // chunk header formats
  localparam logic [1:0] RCS_FMT_FULL    = 2'd0;
  localparam logic [1:0] RCS_FMT_SAME_SID = 2'd1;
  localparam logic [1:0] RCS_FMT_TS_ONLY = 2'd2;
  localparam logic [1:0] RCS_FMT_NONE    = 2'd3;

  // item kinds on tuser
  localparam logic RCS_OP_HEADER  = 1'b0;
  localparam logic RCS_OP_PAYLOAD = 1'b1;

  // register index
  localparam logic RCS_REG_MAX_CHUNK = 1'b0;

  typedef struct packed {
    logic        op;
    logic [16:0] csid;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] sid;
    logic [7:0]  pay;
  } rcs_item_t;

  typedef struct packed {
    logic [1:0]  len;
    logic [23:0] bytes;  // byte 0 in the low bits
  } rcs_bh_t;

  // One queued job: the bytes to send for one accepted item, in order
  // basic header, message header, extended timestamp, payload byte.
  typedef struct packed {
    logic [4:0]  hdr_len;
    logic [1:0]  bh_len;
    logic [23:0] bh_bytes;
    logic [3:0]  mh_len;
    logic [23:0] ts24;
    logic [23:0] len;
    logic [7:0]  mtype;
    logic [31:0] sid;
    logic        ext;
    logic [31:0] ext_val;
    logic        has_pay;
    logic [7:0]  pay;
  } rcs_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rcs_qstat_t;

  function automatic rcs_bh_t rcs_basic_hdr(logic [1:0] fmt, logic [16:0] csid);
    rcs_bh_t     r;
    logic [16:0] d;
    d = csid - RCS_CSID_BASE;
    r = '0;
    if (csid <= RCS_CSID_ONE_MAX) begin
      r.len         = 2'd1;
      r.bytes[7:0]  = {fmt, csid[5:0]};
    end else if (csid <= RCS_CSID_TWO_MAX) begin
      r.len         = 2'd2;
      r.bytes[7:0]  = {fmt, 6'd0};
      r.bytes[15:8] = d[7:0];
    end else begin
      r.len          = 2'd3;
      r.bytes[7:0]   = {fmt, 6'd1};
      r.bytes[15:8]  = d[7:0];
      r.bytes[23:16] = d[15:8];
    end
    return r;
  endfunction

endpackage

// ===== hdl/rtmp_chunk_serializer_unit.sv =====
// Top level of the chunk stream serializer: config register, front end, job queue, back end.
// Depends on rcs_pkg, rcs_front, rcs_fifo, rcs_back and rtmp_chunk_serializer_unit_assert.svh.
//
//  channel   dir  handshake                  carries
//  s_axis    in   s_axis_tvalid/tready       header items and payload bytes
//  m_axis    out  m_axis_tvalid/tready       serialized chunk stream bytes
//  apb       in   psel/penable/pwrite/pready maximum chunk length at byte address 0
//
// One item is accepted per cycle while the four-entry job queue has room.
// The back end sends one byte per cycle while m_axis is not stalled: a header item is
// 1 to 18 bytes, a payload byte one byte, or up to 8 where a continuation header goes first.
// With the queue empty, the first byte of an item is written into the job queue and then
// loaded into the output register, from which it goes out on m_axis.
// Reset clears all message state and sets the maximum chunk length to 128; there is no
// clearing pass.
// A stall on m_axis holds the output register; s_axis keeps flowing until the queue fills.
`include "rtmp_chunk_serializer_unit_assert.svh"

module rtmp_chunk_serializer_unit import rcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [16:0] chunk_stream_id, [48:17] msg_timestamp, [72:49] msg_length,
  // [80:73] msg_type, [112:81] stream_id, [120:113] payload_byte, rest zero
  input  logic [127:0]           s_axis_tdata,
  // [0] op
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_byte, [12:8] header_length, rest zero
  output logic [15:0]            m_axis_tdata,
  // [0] is_header
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RCS_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [16:0] max_chunk_q, max_chunk_d;
  logic        cfg_wr;
  rcs_item_t   item;
  rcs_job_t    push_job;
  rcs_job_t    head_job;
  rcs_qstat_t  q_stat;
  logic        q_push;
  logic        q_pop;
  logic [7:0]  out_byte;
  logic [4:0]  out_hl;

  // Register file: one register, decoded on the word index.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RCS_REG_MAX_CHUNK);
  assign max_chunk_d = cfg_wr ? pwdata[16:0] : max_chunk_q;
  assign prdata = (paddr[2] == RCS_REG_MAX_CHUNK) ? {15'd0, max_chunk_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= RCS_MAX_CHUNK_RST;
    end else begin
      max_chunk_q <= max_chunk_d;
    end
  end

  // Unpack the input transfer.
  always_comb begin
    item.op    = s_axis_tuser;
    item.csid  = s_axis_tdata[16:0];
    item.ts    = s_axis_tdata[48:17];
    item.len   = s_axis_tdata[72:49];
    item.mtype = s_axis_tdata[80:73];
    item.sid   = s_axis_tdata[112:81];
    item.pay   = s_axis_tdata[120:113];
  end

  // Classify and track state; state advances at the transfer itself.
  rcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .max_chunk_i (max_chunk_q),
    .q_full_i    (q_stat.full),
    .push_o      (q_push),
    .job_o       (push_job)
  );

  rcs_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .data_i(push_job),
    .pop_i (q_pop),
    .data_o(head_job),
    .stat_o(q_stat)
  );

  // Serialize the head job byte by byte into the output register.
  rcs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (!q_stat.empty),
    .job_i      (head_job),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (out_byte),
    .out_hdr_o  (m_axis_tuser),
    .out_last_o (m_axis_tlast),
    .out_hl_o   (out_hl)
  );

  assign m_axis_tdata = {3'd0, out_hl, out_byte};

  `RCS_ASSERT_NEVER(a_no_overflow, q_push && q_stat.full && !q_pop, "job queue overflow")
  `RCS_ASSERT(a_no_underflow, q_pop |-> !q_stat.empty, "pop from empty job queue")
  `RCS_ASSERT(a_payload_last, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast, "bad tlast")
  `RCS_ASSERT(a_hl_is_hdr, (m_axis_tvalid && |out_hl) |-> m_axis_tuser, "hl on payload")

endmodule

// ===== hdl/rcs_front.sv =====
// Front end: accepts items, picks the header format, tracks message and chunk state.
// Depends on rcs_pkg; pushes one rcs_job_t per item that produces output.
module rcs_front import rcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rcs_item_t   item_i,
  input  logic [16:0] max_chunk_i,
  input  logic        q_full_i,
  output logic        push_o,
  output rcs_job_t    job_o
);

  logic        have_prev_q, have_prev_d;
  logic [31:0] prev_sid_q, prev_sid_d;
  logic [23:0] prev_len_q, prev_len_d;
  logic [7:0]  prev_type_q, prev_type_d;
  logic [31:0] prev_ts_q, prev_ts_d;
  logic [23:0] left_msg_q, left_msg_d;
  logic [16:0] left_chunk_q, left_chunk_d;
  logic [16:0] cur_csid_q, cur_csid_d;
  logic [32:0] ext_q, ext_d;

  logic        accept;
  logic        same;
  logic [1:0]  fmt;
  logic [31:0] tv;
  logic        tv_ext;
  logic [16:0] csid;
  logic [16:0] eff_cs;
  logic        cont;
  rcs_bh_t     bh_msg;
  rcs_bh_t     bh_cont;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    priority if (max_chunk_i == 17'd0) begin
      eff_cs = 17'd1;
    end else if (max_chunk_i > RCS_MAX_CHUNK_LIMIT) begin
      eff_cs = RCS_MAX_CHUNK_LIMIT;
    end else begin
      eff_cs = max_chunk_i;
    end
    priority if (item_i.csid < RCS_CSID_MIN) begin
      csid = RCS_CSID_MIN;
    end else if (item_i.csid > RCS_CSID_MAX) begin
      csid = RCS_CSID_MAX;
    end else begin
      csid = item_i.csid;
    end
  end

  always_comb begin
    same = have_prev_q && (item_i.sid == prev_sid_q);
    fmt  = RCS_FMT_FULL;
    if (same) begin
      fmt = RCS_FMT_SAME_SID;
      if (item_i.len == prev_len_q && item_i.mtype == prev_type_q) begin
        fmt = RCS_FMT_TS_ONLY;
        if (item_i.ts == prev_ts_q) begin
          fmt = RCS_FMT_NONE;
        end
      end
    end
    tv      = same ? (item_i.ts - prev_ts_q) : item_i.ts;
    tv_ext  = |tv[31:24];
    cont    = (left_chunk_q == 17'd0);
    bh_msg  = rcs_basic_hdr(fmt, csid);
    bh_cont = rcs_basic_hdr(RCS_FMT_NONE, cur_csid_q);
  end

  always_comb begin
    have_prev_d  = have_prev_q;
    prev_sid_d   = prev_sid_q;
    prev_len_d   = prev_len_q;
    prev_type_d  = prev_type_q;
    prev_ts_d    = prev_ts_q;
    left_msg_d   = left_msg_q;
    left_chunk_d = left_chunk_q;
    cur_csid_d   = cur_csid_q;
    ext_d        = ext_q;
    push_o       = 1'b0;
    job_o        = '0;
    job_o.len    = item_i.len;
    job_o.mtype  = item_i.mtype;
    job_o.sid    = item_i.sid;
    job_o.pay    = item_i.pay;

    if (item_i.op == RCS_OP_HEADER) begin
      job_o.bh_len   = bh_msg.len;
      job_o.bh_bytes = bh_msg.bytes;
      unique case (fmt)
        RCS_FMT_FULL:     job_o.mh_len = 4'd11;
        RCS_FMT_SAME_SID: job_o.mh_len = 4'd7;
        RCS_FMT_TS_ONLY:  job_o.mh_len = 4'd3;
        default:          job_o.mh_len = 4'd0;
      endcase
      job_o.ts24    = tv_ext ? 24'hFFFFFF : tv[23:0];
      job_o.ext     = tv_ext;
      job_o.ext_val = tv;
      job_o.hdr_len = {3'd0, bh_msg.len} + {1'b0, job_o.mh_len} + (tv_ext ? 5'd4 : 5'd0);
      // zero-length messages leave everything untouched
      if (accept && item_i.len != 24'd0) begin
        push_o       = 1'b1;
        have_prev_d  = 1'b1;
        prev_sid_d   = item_i.sid;
        prev_len_d   = item_i.len;
        prev_type_d  = item_i.mtype;
        prev_ts_d    = item_i.ts;
        cur_csid_d   = csid;
        left_msg_d   = item_i.len;
        left_chunk_d = eff_cs;
        ext_d        = {tv_ext, tv_ext ? tv : 32'd0};
      end
    end else begin
      job_o.bh_len   = cont ? bh_cont.len : 2'd0;
      job_o.bh_bytes = bh_cont.bytes;
      job_o.ext      = cont && ext_q[32];
      job_o.ext_val  = ext_q[31:0];
      job_o.has_pay  = 1'b1;
      // drop stray payload bytes outside a message
      if (accept && left_msg_q != 24'd0) begin
        push_o       = 1'b1;
        left_msg_d   = left_msg_q - 24'd1;
        left_chunk_d = (cont ? eff_cs : left_chunk_q) - 17'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q  <= 1'b0;
      prev_sid_q   <= '0;
      prev_len_q   <= '0;
      prev_type_q  <= '0;
      prev_ts_q    <= '0;
      left_msg_q   <= '0;
      left_chunk_q <= '0;
      cur_csid_q   <= '0;
      ext_q        <= '0;
    end else begin
      have_prev_q  <= have_prev_d;
      prev_sid_q   <= prev_sid_d;
      prev_len_q   <= prev_len_d;
      prev_type_q  <= prev_type_d;
      prev_ts_q    <= prev_ts_d;
      left_msg_q   <= left_msg_d;
      left_chunk_q <= left_chunk_d;
      cur_csid_q   <= cur_csid_d;
      ext_q        <= ext_d;
    end
  end

endmodule

// ===== hdl/rcs_fifo.sv =====
// Job queue between front and back end, RCS_QDEPTH entries of rcs_job_t.
// Depends on rcs_pkg.
module rcs_fifo import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rcs_job_t   data_i,
  input  logic       pop_i,
  output rcs_job_t   data_o,
  output rcs_qstat_t stat_o
);

  rcs_job_t              mem_q [RCS_QDEPTH];
  logic [RCS_QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RCS_QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RCS_QPTR_W:0]   count_q, count_d;

  localparam logic [RCS_QPTR_W:0] Depth = (RCS_QPTR_W + 1)'(RCS_QDEPTH);

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == Depth);
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (RCS_QPTR_W + 1)'(push_i) - (RCS_QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hdl/rcs_back.sv =====
// Back end: walks the bytes of the job at the queue head into an output register.
// Depends on rcs_pkg.
module rcs_back import rcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  rcs_job_t job_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic [7:0] out_byte_o,
  output logic     out_hdr_o,
  output logic     out_last_o,
  output logic [4:0] out_hl_o
);

  logic [4:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       hdr_q, hdr_d;
  logic       last_q, last_d;
  logic [4:0] hl_q;

  logic       load;
  logic [4:0] e1, e2, e3, n;
  logic [4:0] off2, off3;
  logic [3:0] mk;
  logic [1:0] xk;
  logic [7:0] mh_byte;
  logic [7:0] ext_byte;

  assign load = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    e1   = {3'd0, job_i.bh_len};
    e2   = e1 + {1'b0, job_i.mh_len};
    e3   = e2 + (job_i.ext ? 5'd4 : 5'd0);
    n    = e3 + {4'd0, job_i.has_pay};
    off2 = idx_q - e1;
    off3 = idx_q - e2;
    mk   = off2[3:0];
    xk   = off3[1:0];
    unique case (mk)
      4'd0:    mh_byte = job_i.ts24[23:16];
      4'd1:    mh_byte = job_i.ts24[15:8];
      4'd2:    mh_byte = job_i.ts24[7:0];
      4'd3:    mh_byte = job_i.len[23:16];
      4'd4:    mh_byte = job_i.len[15:8];
      4'd5:    mh_byte = job_i.len[7:0];
      4'd6:    mh_byte = job_i.mtype;
      4'd7:    mh_byte = job_i.sid[7:0];
      4'd8:    mh_byte = job_i.sid[15:8];
      4'd9:    mh_byte = job_i.sid[23:16];
      4'd10:   mh_byte = job_i.sid[31:24];
      default: mh_byte = 8'h00;
    endcase
    unique case (xk)
      2'd0:    ext_byte = job_i.ext_val[31:24];
      2'd1:    ext_byte = job_i.ext_val[23:16];
      2'd2:    ext_byte = job_i.ext_val[15:8];
      default: ext_byte = job_i.ext_val[7:0];
    endcase
  end

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    byte_d  = byte_q;
    hdr_d   = hdr_q;
    last_d  = last_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      hdr_d   = 1'b1;
      priority if (idx_q < e1) begin
        byte_d = job_i.bh_bytes[{idx_q[1:0], 3'b000} +: 8];
      end else if (idx_q < e2) begin
        byte_d = mh_byte;
      end else if (idx_q < e3) begin
        byte_d = ext_byte;
      end else begin
        byte_d = job_i.pay;
        hdr_d  = 1'b0;
      end
      last_d = (idx_q == n - 5'd1);
      if (last_d) begin
        idx_d = '0;
        pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    last_q <= last_d;
    if (load) begin
      hl_q <= job_i.hdr_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_hdr_o   = hdr_q;
  assign out_last_o  = last_q;
  assign out_hl_o    = hl_q;

endmodule

// ===== dv/rtmp_chunk_serializer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the chunk stream serializer: predicts the output byte stream from
// the accepted items and maximum chunk length writes, and compares transfer by transfer.
// Depends on rcs_pkg for the format, op, register and csid constants.
module rtmp_chunk_serializer_checker import rcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // [16:0] chunk_stream_id, [48:17] msg_timestamp, [72:49] msg_length,
  // [80:73] msg_type, [112:81] stream_id, [120:113] payload_byte
  input  logic [127:0]           s_axis_tdata,
  // [0] op
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] out_byte, [12:8] header_length
  input  logic [15:0]            m_axis_tdata,
  // [0] is_header
  input  logic                   m_axis_tuser,
  input  logic                   m_axis_tlast,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [RCS_PADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  output int                     mismatch_count_o,
  output int                     pending_o
);

  localparam logic [31:0] TS_FIELD_MAX = 32'h00FF_FFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       tlast;
    logic [4:0] hlen;
  } chunk_byte_t;

  chunk_byte_t expected_bytes[$];
  logic [7:0]  hdr_bytes[$];
  chunk_byte_t want;
  int          mismatches = 0;

  // serializer state as seen from outside
  logic [16:0] max_chunk_reg;
  logic        have_prev;
  logic [31:0] prev_sid;
  logic [23:0] prev_len;
  logic [7:0]  prev_mtype;
  logic [31:0] prev_ts;
  logic [23:0] msg_left;
  logic [16:0] chunk_left;
  logic [16:0] cur_csid;
  logic        ext_on;
  logic [31:0] ext_val;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t checker: %s", $time, msg);
  endtask

  function automatic logic [16:0] chunk_limit();
    if (max_chunk_reg == '0) return 17'd1;
    if (max_chunk_reg > RCS_MAX_CHUNK_LIMIT) return RCS_MAX_CHUNK_LIMIT;
    return max_chunk_reg;
  endfunction

  task automatic put_basic_header(input logic [1:0] fmt, input logic [16:0] csid);
    logic [16:0] d;
    d = csid - RCS_CSID_BASE;
    if (csid <= RCS_CSID_ONE_MAX) begin
      hdr_bytes.push_back({fmt, csid[5:0]});
    end else if (csid <= RCS_CSID_TWO_MAX) begin
      hdr_bytes.push_back({fmt, 6'd0});
      hdr_bytes.push_back(d[7:0]);
    end else begin
      hdr_bytes.push_back({fmt, 6'd1});
      hdr_bytes.push_back(d[7:0]);
      hdr_bytes.push_back(d[15:8]);
    end
  endtask

  task automatic put_be32(input logic [31:0] v);
    hdr_bytes.push_back(v[31:24]);
    hdr_bytes.push_back(v[23:16]);
    hdr_bytes.push_back(v[15:8]);
    hdr_bytes.push_back(v[7:0]);
  endtask

  task automatic emit_header_bytes(input logic [4:0] hlen, input logic close);
    for (int i = 0; i < hdr_bytes.size(); i++)
      expected_bytes.push_back(chunk_byte_t'{hdr_bytes[i], 1'b1,
                                             close && (i == hdr_bytes.size() - 1), hlen});
  endtask

  task automatic encode_header(input logic [16:0] csid_in, input logic [31:0] ts,
                               input logic [23:0] len, input logic [7:0] mtype,
                               input logic [31:0] sid);
    logic [16:0] csid;
    logic [1:0]  fmt;
    logic [31:0] delta;
    logic [23:0] ts_field;
    // zero-length message: nothing out, state untouched
    if (len == '0) return;
    csid = csid_in;
    if (csid < RCS_CSID_MIN) csid = RCS_CSID_MIN;
    if (csid > RCS_CSID_MAX) csid = RCS_CSID_MAX;
    fmt   = RCS_FMT_FULL;
    delta = ts;
    if (have_prev && sid == prev_sid) begin
      fmt = RCS_FMT_SAME_SID;
      if (len == prev_len && mtype == prev_mtype) begin
        fmt = RCS_FMT_TS_ONLY;
        if (ts == prev_ts) fmt = RCS_FMT_NONE;
      end
      delta = ts - prev_ts;
    end
    hdr_bytes.delete();
    put_basic_header(fmt, csid);
    ts_field = (delta > TS_FIELD_MAX) ? 24'hFF_FFFF : delta[23:0];
    if (fmt != RCS_FMT_NONE) begin
      hdr_bytes.push_back(ts_field[23:16]);
      hdr_bytes.push_back(ts_field[15:8]);
      hdr_bytes.push_back(ts_field[7:0]);
    end
    if (fmt == RCS_FMT_FULL || fmt == RCS_FMT_SAME_SID) begin
      hdr_bytes.push_back(len[23:16]);
      hdr_bytes.push_back(len[15:8]);
      hdr_bytes.push_back(len[7:0]);
      hdr_bytes.push_back(mtype);
    end
    // stream id goes out little endian
    if (fmt == RCS_FMT_FULL) begin
      hdr_bytes.push_back(sid[7:0]);
      hdr_bytes.push_back(sid[15:8]);
      hdr_bytes.push_back(sid[23:16]);
      hdr_bytes.push_back(sid[31:24]);
    end
    ext_on  = delta > TS_FIELD_MAX;
    ext_val = delta;
    if (ext_on) put_be32(delta);
    emit_header_bytes(5'(hdr_bytes.size()), 1'b1);
    have_prev  = 1'b1;
    prev_sid   = sid;
    prev_len   = len;
    prev_mtype = mtype;
    prev_ts    = ts;
    cur_csid   = csid;
    msg_left   = len;
    chunk_left = chunk_limit();
  endtask

  task automatic encode_payload(input logic [7:0] pay);
    // drop stray bytes outside a message
    if (msg_left == '0) return;
    hdr_bytes.delete();
    if (chunk_left == '0) begin
      // continuation: type 3 basic header plus any extended timestamp
      put_basic_header(RCS_FMT_NONE, cur_csid);
      if (ext_on) put_be32(ext_val);
      chunk_left = chunk_limit();
    end
    emit_header_bytes(5'd0, 1'b0);
    expected_bytes.push_back(chunk_byte_t'{pay, 1'b0, 1'b1, 5'd0});
    chunk_left--;
    msg_left--;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_reg  = RCS_MAX_CHUNK_RST;
      have_prev      = 1'b0;
      prev_sid       = '0;
      prev_len       = '0;
      prev_mtype     = '0;
      prev_ts        = '0;
      msg_left       = '0;
      chunk_left     = '0;
      cur_csid       = '0;
      ext_on         = 1'b0;
      ext_val        = '0;
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      // compare first, so a new item never pairs with a stray output of this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", m_axis_tdata[7:0]));
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata[7:0] != want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      m_axis_tdata[7:0], want.data));
          if (m_axis_tuser != want.hdr)
            report_mismatch($sformatf("is_header %0b, expected %0b", m_axis_tuser, want.hdr));
          if (m_axis_tlast != want.tlast)
            report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, want.tlast));
          if (m_axis_tdata[12:8] != want.hlen)
            report_mismatch($sformatf("header_length %0d, expected %0d",
                                      m_axis_tdata[12:8], want.hlen));
        end
      end
      if (psel && penable && pwrite && pready && paddr == {RCS_REG_MAX_CHUNK, 2'b00})
        max_chunk_reg = pwdata[16:0];
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == RCS_OP_PAYLOAD)
          encode_payload(s_axis_tdata[120:113]);
        else
          encode_header(s_axis_tdata[16:0], s_axis_tdata[48:17], s_axis_tdata[72:49],
                        s_axis_tdata[80:73], s_axis_tdata[112:81]);
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ===== dv/tb_rtmp_chunk_serializer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for rtmp_chunk_serializer_unit: drives header items, payload bytes
// and maximum chunk length writes, and gives the verdict; checking lives in the checker.
// Depends on rcs_pkg, rtmp_chunk_serializer_unit and rtmp_chunk_serializer_checker.
module tb_rtmp_chunk_serializer_unit;
  import rcs_pkg::*;

  localparam int IDLE_MAX        = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_ITEMS    = 160;
  localparam int PHASE_ITEMS     = 18;
  // chunk sizes per phase: extremes, the clamped values and a few small ones
  localparam logic [31:0] CHUNK_PLAN [10] = '{32'd1, 32'd0, 32'd2, 32'd65536, 32'd3,
                                              32'h1FFFF, 32'd5, 32'd1, 32'd4, 32'd8};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [16:0] chunk_stream_id, [48:17] msg_timestamp, [72:49] msg_length,
  // [80:73] msg_type, [112:81] stream_id, [120:113] payload_byte, rest zero
  logic [127:0]           s_axis_tdata  = '0;
  // [0] op
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [7:0] out_byte, [12:8] header_length, rest zero
  logic [15:0]            m_axis_tdata;
  // [0] is_header
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [RCS_PADDR_W-1:0] paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int mismatch_count;
  int pending;

  // handshake between the stimulus and the sink process
  bit hold_off_req = 1'b0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  // last message header sent, used to steer toward the compressed formats
  bit          gen_valid = 1'b0;
  logic [31:0] gen_sid   = '0;
  logic [31:0] gen_ts    = '0;
  logic [23:0] gen_len   = '0;
  logic [7:0]  gen_mtype = '0;
  int          items_sent = 0;

  always #5 clk_i = ~clk_i;

  rtmp_chunk_serializer_unit dut (.*);

  rtmp_chunk_serializer_checker u_checker (
    .*,
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  // Offer one item after a random idle gap and hold it until the transfer.
  // Call at a rising edge; returns at the edge of the transfer with tvalid still high.
  task automatic send_item(input logic op, input logic [16:0] csid, input logic [31:0] ts,
                           input logic [23:0] len, input logic [7:0] mtype,
                           input logic [31:0] sid, input logic [7:0] pay);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, pay, sid, mtype, len, ts, csid};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Randomize the unused fields so their bits toggle on every kind of item.
  task automatic send_header(input logic [16:0] csid, input logic [31:0] ts,
                             input logic [23:0] len, input logic [7:0] mtype,
                             input logic [31:0] sid);
    send_item(RCS_OP_HEADER, csid, ts, len, mtype, sid, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pay);
    send_item(RCS_OP_PAYLOAD, 17'($urandom), $urandom, 24'($urandom), 8'($urandom),
              $urandom, pay);
  endtask

  // Drop tvalid, wait until every predicted byte has come out, then let the
  // back end settle on items that produce nothing.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One message: a header that often repeats the last stream id, length, type or
  // timestamp, then its payload, now and then cut short or followed by stray bytes.
  task automatic send_message(input int fixed_len);
    logic [16:0] csid;
    logic [31:0] sid;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  mtype;
    int          roll;
    int          nbytes;
    case ($urandom_range(0, 3))
      0:       csid = 17'($urandom_range(2, 63));
      1:       csid = 17'($urandom_range(64, 319));
      2:       csid = 17'($urandom_range(320, 65599));
      default: csid = 17'($urandom);
    endcase
    sid  = (gen_valid && $urandom_range(0, 3) != 0) ? gen_sid : $urandom;
    roll = $urandom_range(0, 99);
    if (fixed_len != 0)                            len = 24'(fixed_len);
    else if (roll < 5)                             len = '0;
    else if (roll < 12)                            len = 24'($urandom);
    else if (gen_valid && $urandom_range(0, 1) != 0) len = gen_len;
    else                                           len = 24'($urandom_range(1, 12));
    mtype = (gen_valid && $urandom_range(0, 1) != 0) ? gen_mtype : 8'($urandom);
    // same timestamp, small step, step around the extended timestamp boundary, anything
    case ($urandom_range(0, 3))
      0:       ts = gen_ts;
      1:       ts = gen_ts + 32'($urandom_range(1, 1000));
      2:       ts = gen_ts + 32'h00FF_FFFF + 32'($urandom_range(0, 2));
      default: ts = $urandom;
    endcase
    send_header(csid, ts, len, mtype, sid);
    if (len != '0) begin
      gen_valid = 1'b1;
      gen_sid   = sid;
      gen_ts    = ts;
      gen_len   = len;
      gen_mtype = mtype;
    end
    // long messages are only started, then abandoned by the next header
    nbytes = (len > 24'd40) ? $urandom_range(1, 8) : int'(len);
    roll   = $urandom_range(0, 9);
    if (roll == 0)      nbytes = $urandom_range(0, nbytes);
    else if (roll == 1) nbytes += $urandom_range(1, 2);
    for (int k = 0; k < nbytes; k++) send_payload(8'($urandom));
    if (len != '0) items_sent += 1 + ((nbytes < int'(len)) ? nbytes : int'(len));
  endtask

  // Sink: draw an idle gap per transfer, with long ready stretches, and one long
  // hold-off on request so the job queue fills and s_axis backs up.
  initial begin : sink
    int gap;
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, IDLE_MAX);
      if (hold_off_req) begin
        gap          = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    int phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset chunk size of 128.
    // Stray payload byte before any message: ignored.
    send_payload(8'h5A);
    // First header, csid below range, absolute timestamp needing the extended field.
    send_header(17'd0, 32'h0100_0000, 24'd2, 8'h00, 32'd0);
    send_payload(8'h00);
    send_payload(8'hFF);
    // Zero-length message: emits nothing.
    send_header(17'd5, 32'h0000_1234, 24'd0, 8'h07, 32'd9);
    // Everything repeats: type 3 header, largest one-byte csid.
    send_header(17'd63, 32'h0100_0000, 24'd2, 8'h00, 32'd0);
    send_payload(8'hA5);
    send_payload(8'h3C);
    // Only the timestamp moves: type 2, smallest two-byte csid; abandon after one byte.
    send_header(17'd64, 32'h0100_0005, 24'd2, 8'h00, 32'd0);
    send_payload(8'h81);
    // Length and type change: type 1, largest two-byte csid.
    send_header(17'd319, 32'h0100_0005, 24'd1, 8'hFF, 32'd0);
    send_payload(8'h7E);
    // New stream id, all fields at their maximum, smallest three-byte csid; abandon.
    send_header(17'd320, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_payload(8'h01);
    send_payload(8'hFE);
    // Timestamp wraps to a delta of one: type 1, largest csid.
    send_header(17'd65599, 32'h0000_0000, 24'd1, 8'h80, 32'hFFFF_FFFF);
    send_payload(8'h55);
    // Large delta with a matching length and type: type 2 plus extended timestamp,
    // csid above range; then a byte past the end of the message.
    send_header(17'h1FFFF, 32'h8000_0000, 24'd1, 8'h80, 32'hFFFF_FFFF);
    send_payload(8'hAA);
    send_payload(8'hC3);

    // Random phases, each behind its own maximum chunk length write while idle.
    for (phase = 0; items_sent < RANDOM_ITEMS; phase++) begin
      wait_drained();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= {RCS_REG_MAX_CHUNK, 2'b00};
      pwdata  <= (phase < 10) ? CHUNK_PLAN[phase] : 32'($urandom_range(1, 9));
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // back up the whole pipe once: long sink stall under a steady message
      if (phase == 1) begin
        hold_off_req = 1'b1;
        send_message(24);
      end
      while (items_sent < (phase + 1) * PHASE_ITEMS) send_message(0);
    end

    wait_drained();
    if (mismatch_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== rtmp_chunk_serializer_unit.f =====
+incdir+hdl
hdl/rcs_pkg.sv
hdl/rcs_front.sv
hdl/rcs_fifo.sv
hdl/rcs_back.sv
hdl/rtmp_chunk_serializer_unit.sv
dv/rtmp_chunk_serializer_checker.sv
dv/tb_rtmp_chunk_serializer_unit.sv
